// ===== src/ssw_pkg.sv =====
// Shared types and constants for the sign-segmented weighted mean block.
// No dependencies; imported by the divider, front part, back part and top level.
`default_nettype none
package ssw_pkg;

  localparam int DIV_W = 64;
  localparam int DIV_CNT_W = 7;

  // Segment sign codes
  localparam logic [1:0] SEG_NONE = 2'd0;
  localparam logic [1:0] SEG_POS  = 2'd1;
  localparam logic [1:0] SEG_NEG  = 2'd2;
  localparam logic [1:0] SEG_ZERO = 2'd3;

  typedef struct packed {
    logic [15:0] run;
    logic [31:0] meas;
    logic [31:0] unc;
    logic [1:0]  sign;
    logic        new_seg;
    logic        emit_before;
    logic        emit_after;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        first_run;
    logic signed [31:0] mean;
    logic [31:0]        mean_error;
    logic               negative_group;
    logic               no_weight;
    logic               last_result;
  } res_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     rem0;
    logic [DIV_W-1:0]     num;
    logic [DIV_W-1:0]     divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/ssw_div.sv =====
// Shared restoring divider, one quotient bit per cycle while busy.
// Depends on ssw_pkg (request and response structs).
`default_nettype none
module ssw_div import ssw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]     rem_r, num_r, d_r, q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [DIV_W:0]       shifted, diff;
  logic                 ge;
  logic [DIV_W-1:0]     rem_nxt;

  assign shifted = {rem_r, num_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, d_r};
  assign diff    = shifted - {1'b0, d_r};
  assign rem_nxt = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem0;
      num_r <= req.num;
      d_r   <= req.divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[DIV_W-2:0], 1'b0};
      q_r   <= {q_r[DIV_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule
`default_nettype wire

// ===== src/ssw_front.sv =====
// Front part: accepts items, classifies them by polarization sign and queues commands.
// Depends on ssw_pkg (cmd_t, segment sign codes).
`default_nettype none
module ssw_front import ssw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [15:0]        in_run_number,
  input  logic signed [15:0] in_polarization,
  input  logic signed [31:0] in_measurement,
  input  logic [31:0]        in_uncertainty,
  input  logic               in_end_of_data,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_pop
);

  logic [1:0] sign_r, sign_nxt, s;
  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       acc, pop;
  cmd_t       c;

  assign acc = in_push && !in_full;
  assign pop = cmd_pop && cmd_valid;

  always_comb begin
    if (in_polarization == 16'sd0) begin
      s = SEG_ZERO;
    end else if (in_polarization[15]) begin
      s = SEG_NEG;
    end else begin
      s = SEG_POS;
    end
    c.run         = in_run_number;
    c.meas        = in_measurement;
    c.unc         = in_uncertainty;
    c.sign        = s;
    c.emit_before = (sign_r != SEG_NONE) && ((s != sign_r) || (s == SEG_ZERO));
    c.new_seg     = (sign_r == SEG_NONE) || c.emit_before;
    c.emit_after  = in_end_of_data || (s == SEG_ZERO);
    sign_nxt      = c.emit_after ? SEG_NONE : s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_r <= SEG_NONE;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (acc) begin
        sign_r <= sign_nxt;
        wp_r   <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, acc} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wp_r] <= c;
    end
  end

  assign in_full   = cnt_r == 2'd2;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rp_r];

endmodule
`default_nettype wire

// ===== src/ssw_back.sv =====
// Back part: sequencer for weights, sums, mean and error, plus the result queue.
// Depends on ssw_pkg and instantiates ssw_div.
`default_nettype none
module ssw_back import ssw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_invert_negative,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic out_empty,
  input  logic out_pop,
  output res_t res
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ECHK  = 4'd1;
  localparam logic [3:0] S_EDIV  = 4'd2;
  localparam logic [3:0] S_EREC  = 4'd3;
  localparam logic [3:0] S_ERW   = 4'd4;
  localparam logic [3:0] S_ESQ   = 4'd5;
  localparam logic [3:0] S_EPUSH = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_ASQ   = 4'd8;
  localparam logic [3:0] S_ARW   = 4'd9;
  localparam logic [3:0] S_AM1   = 4'd10;
  localparam logic [3:0] S_AM2   = 4'd11;
  localparam logic [3:0] S_AADD  = 4'd12;
  localparam logic [3:0] S_AFTER = 4'd13;

  function automatic logic is_pow2(input logic [63:0] d);
    return (d != 64'd0) && ((d & (d - 64'd1)) == 64'd0);
  endfunction

  function automatic logic [31:0] fix_mean(input logic neg, input logic sat,
                                           input logic [31:0] q, input logic inv);
    logic [31:0] m;
    if (sat) begin
      m = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      m = neg ? (32'd0 - q) : q;
    end
    if (inv) begin
      m = (m == 32'h8000_0000) ? 32'h7FFF_FFFF : (32'd0 - m);
    end
    return m;
  endfunction

  logic [3:0]         state_r, state_nxt;
  logic               inv_r;
  cmd_t               cmd_r, cmd_nxt;
  logic [1:0]         seg_sign_r, seg_sign_nxt;
  logic [15:0]        first_run_r, first_run_nxt;
  logic [63:0]        ws_r, ws_nxt;
  logic signed [63:0] wvs_r, wvs_nxt;
  logic               any_r, any_nxt;
  logic               last_r, last_nxt;
  logic               ret_idle_r, ret_idle_nxt;
  logic [63:0]        prod_r, prod_nxt, w_r, w_nxt, phi_r, phi_nxt, x_r, x_nxt;
  logic [31:0]        mean_r, mean_nxt, err_r, err_nxt, root_r, root_nxt;
  logic [35:0]        srem_r, srem_nxt;
  logic [4:0]         scnt_r, scnt_nxt;

  res_t       ofifo_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;
  logic       opush, opop;
  res_t       ores;

  div_req_t   dreq;
  div_rsp_t   drsp;

  logic [31:0] vmag, mul_a, mul_b;
  logic [63:0] mul_p, mag, p, term;
  logic [64:0] ws_sum;
  logic signed [63:0] wv_sum;
  logic        neg_group;
  logic [35:0] srem_in, trial;
  logic        sq_ge;
  logic [31:0] root_step;

  ssw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign vmag      = cmd_r.meas[31] ? (32'd0 - cmd_r.meas) : cmd_r.meas;
  assign mul_a     = (state_r == S_ACC) ? cmd_r.unc : vmag;
  assign mul_b     = (state_r == S_ACC) ? cmd_r.unc :
                     (state_r == S_AM1) ? w_r[63:32] : w_r[31:0];
  assign mul_p     = 64'(mul_a) * 64'(mul_b);
  assign mag       = wvs_r[63] ? (64'd0 - wvs_r) : wvs_r;
  assign neg_group = (seg_sign_r != SEG_POS) || !any_r;
  assign p         = phi_r + {32'd0, prod_r[63:32]};
  assign term      = cmd_r.meas[31] ? (64'd0 - p) : p;
  assign ws_sum    = {1'b0, ws_r} + {1'b0, w_r};
  assign wv_sum    = wvs_r + $signed(term);
  assign srem_in   = {srem_r[33:0], x_r[63:62]};
  assign trial     = {2'b00, root_r, 2'b01};
  assign sq_ge     = srem_in >= trial;
  assign root_step = {root_r[30:0], sq_ge};

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    seg_sign_nxt  = seg_sign_r;
    first_run_nxt = first_run_r;
    ws_nxt        = ws_r;
    wvs_nxt       = wvs_r;
    any_nxt       = any_r;
    last_nxt      = last_r;
    ret_idle_nxt  = ret_idle_r;
    prod_nxt      = prod_r;
    w_nxt         = w_r;
    phi_nxt       = phi_r;
    x_nxt         = x_r;
    mean_nxt      = mean_r;
    err_nxt       = err_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;
    scnt_nxt      = scnt_r;
    cmd_pop       = 1'b0;
    opush         = 1'b0;
    dreq.start    = 1'b0;
    dreq.rem0     = 64'd0;
    dreq.num      = {64{1'b1}};
    dreq.divisor  = prod_r;
    dreq.steps    = DIV_CNT_W'(64);
    ores.first_run      = first_run_r;
    ores.mean           = mean_r;
    ores.mean_error     = err_r;
    ores.negative_group = neg_group;
    ores.no_weight      = !any_r;
    ores.last_result    = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          if (cmd.emit_before) begin
            last_nxt     = !cmd.emit_after;
            ret_idle_nxt = 1'b0;
            state_nxt    = S_ECHK;
          end else begin
            state_nxt = S_ACC;
          end
        end
      end
      S_ECHK: begin
        if (!any_r || (ws_r == 64'd0)) begin
          mean_nxt  = 32'd0;
          err_nxt   = 32'hFFFF_FFFF;
          state_nxt = S_EPUSH;
        end else if ({mag, 1'b0} >= {1'b0, ws_r}) begin
          // quotient reaches 2^31: clamp without dividing
          mean_nxt  = fix_mean(wvs_r[63], 1'b1, 32'd0, neg_group && inv_r);
          state_nxt = S_EREC;
        end else begin
          dreq.start   = 1'b1;
          dreq.rem0    = mag;
          dreq.num     = 64'd0;
          dreq.divisor = ws_r;
          dreq.steps   = DIV_CNT_W'(32);
          state_nxt    = S_EDIV;
        end
      end
      S_EDIV: begin
        dreq.divisor = ws_r;
        if (drsp.done) begin
          mean_nxt  = fix_mean(wvs_r[63], 1'b0, drsp.quot[31:0], neg_group && inv_r);
          state_nxt = S_EREC;
        end
      end
      S_EREC: begin
        if (ws_r == 64'd1) begin
          err_nxt   = 32'hFFFF_FFFF;
          state_nxt = S_EPUSH;
        end else begin
          dreq.start   = 1'b1;
          dreq.divisor = ws_r;
          state_nxt    = S_ERW;
        end
      end
      S_ERW: begin
        dreq.divisor = ws_r;
        if (drsp.done) begin
          x_nxt     = drsp.quot + {63'd0, is_pow2(ws_r)};
          root_nxt  = 32'd0;
          srem_nxt  = 36'd0;
          scnt_nxt  = 5'd31;
          state_nxt = S_ESQ;
        end
      end
      S_ESQ: begin
        srem_nxt = sq_ge ? (srem_in - trial) : srem_in;
        root_nxt = root_step;
        x_nxt    = {x_r[61:0], 2'b00};
        scnt_nxt = scnt_r - 5'd1;
        if (scnt_r == 5'd0) begin
          err_nxt   = root_step;
          state_nxt = S_EPUSH;
        end
      end
      S_EPUSH: begin
        if (ocnt_r != 2'd2) begin
          opush        = 1'b1;
          seg_sign_nxt = SEG_NONE;
          ws_nxt       = 64'd0;
          wvs_nxt      = 64'sd0;
          any_nxt      = 1'b0;
          state_nxt    = ret_idle_r ? S_IDLE : S_ACC;
        end
      end
      S_ACC: begin
        if (cmd_r.new_seg) begin
          seg_sign_nxt  = cmd_r.sign;
          first_run_nxt = cmd_r.run;
          ws_nxt        = 64'd0;
          wvs_nxt       = 64'sd0;
          any_nxt       = 1'b0;
        end
        if (cmd_r.unc == 32'd0) begin
          state_nxt = S_AFTER;
        end else begin
          prod_nxt  = mul_p;
          state_nxt = S_ASQ;
        end
      end
      S_ASQ: begin
        if (prod_r == 64'd1) begin
          w_nxt     = {64{1'b1}};
          state_nxt = S_AM1;
        end else begin
          dreq.start = 1'b1;
          state_nxt  = S_ARW;
        end
      end
      S_ARW: begin
        if (drsp.done) begin
          w_nxt     = drsp.quot + {63'd0, is_pow2(prod_r)};
          state_nxt = S_AM1;
        end
      end
      S_AM1: begin
        prod_nxt  = mul_p;
        state_nxt = S_AM2;
      end
      S_AM2: begin
        phi_nxt   = prod_r;
        prod_nxt  = mul_p;
        state_nxt = S_AADD;
      end
      S_AADD: begin
        ws_nxt = ws_sum[64] ? {64{1'b1}} : ws_sum[63:0];
        if ((wvs_r[63] == term[63]) && (wv_sum[63] != wvs_r[63])) begin
          wvs_nxt = wvs_r[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
          wvs_nxt = wv_sum;
        end
        any_nxt   = 1'b1;
        state_nxt = S_AFTER;
      end
      S_AFTER: begin
        if (cmd_r.emit_after) begin
          last_nxt     = 1'b1;
          ret_idle_nxt = 1'b1;
          state_nxt    = S_ECHK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign opop = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      inv_r      <= 1'b1;
      seg_sign_r <= SEG_NONE;
      ws_r       <= 64'd0;
      wvs_r      <= 64'sd0;
      any_r      <= 1'b0;
      first_run_r <= 16'd0;
      owp_r      <= 1'b0;
      orp_r      <= 1'b0;
      ocnt_r     <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      seg_sign_r  <= seg_sign_nxt;
      ws_r        <= ws_nxt;
      wvs_r       <= wvs_nxt;
      any_r       <= any_nxt;
      first_run_r <= first_run_nxt;
      if (cfg_we) begin
        inv_r <= cfg_invert_negative;
      end
      if (opush) begin
        owp_r <= ~owp_r;
      end
      if (opop) begin
        orp_r <= ~orp_r;
      end
      ocnt_r <= ocnt_r + {1'b0, opush} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    last_r     <= last_nxt;
    ret_idle_r <= ret_idle_nxt;
    prod_r     <= prod_nxt;
    w_r        <= w_nxt;
    phi_r      <= phi_nxt;
    x_r        <= x_nxt;
    mean_r     <= mean_nxt;
    err_r      <= err_nxt;
    root_r     <= root_nxt;
    srem_r     <= srem_nxt;
    scnt_r     <= scnt_nxt;
    if (opush) begin
      ofifo_r[owp_r] <= ores;
    end
  end

  assign out_empty = ocnt_r == 2'd0;
  assign res       = ofifo_r[orp_r];

endmodule
`default_nettype wire

// ===== src/sign_segmented_weighted_mean.sv =====
// Top level of the sign-segmented inverse-variance weighted mean block.
// Depends on ssw_pkg; instantiates ssw_front and ssw_back.
//
//   channel  direction  handshake             payload
//   in_      in         in_push / in_full     run, polarization, value, error, end flag
//   out_     out        out_empty / out_pop   first run, mean, error, group, flags
//   cfg_     in         cfg_we                invert_negative
//
// An item with zero uncertainty skips the weight arithmetic in the back part; a counted item
// is dominated by the 64-step weight reciprocal on the shared one-bit-per-cycle divider.
// Each result adds up to a 32-step mean division, a 64-step reciprocal of the weight
// sum, a 32-step square root and its control states.
// Reset is synchronous and active low; invert_negative resets to 1.
// A two-entry command queue and a two-entry result queue let each side stall alone;
// a full result queue holds the back part at its push cycle.
`default_nettype none
module sign_segmented_weighted_mean import ssw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_invert_negative,
  input  logic               in_push,
  output logic               in_full,
  input  logic [15:0]        in_run_number,
  input  logic signed [15:0] in_polarization,
  input  logic signed [31:0] in_measurement,
  input  logic [31:0]        in_uncertainty,
  input  logic               in_end_of_data,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [15:0]        out_first_run,
  output logic signed [31:0] out_mean,
  output logic [31:0]        out_mean_error,
  output logic               out_negative_group,
  output logic               out_no_weight,
  output logic               out_last_result
);

  // classified commands from front to back
  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  ssw_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_run_number   (in_run_number),
    .in_polarization (in_polarization),
    .in_measurement  (in_measurement),
    .in_uncertainty  (in_uncertainty),
    .in_end_of_data  (in_end_of_data),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  // sums, weights and result arithmetic; the oldest result sits on res
  ssw_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_invert_negative (cfg_invert_negative),
    .cmd_valid           (cmd_valid),
    .cmd                 (cmd),
    .cmd_pop             (cmd_pop),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .res                 (res)
  );

  assign out_first_run      = res.first_run;
  assign out_mean           = res.mean;
  assign out_mean_error     = res.mean_error;
  assign out_negative_group = res.negative_group;
  assign out_no_weight      = res.no_weight;
  assign out_last_result    = res.last_result;

endmodule
`default_nettype wire

// ===== src/ssw_checker.sv =====
// Port-level assertions for the weighted mean block, and the bind that attaches them.
// Depends on the top level's ports only.
`default_nettype none
module ssw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic [15:0]        out_first_run,
  input logic signed [31:0] out_mean,
  input logic [31:0]        out_mean_error,
  input logic               out_negative_group,
  input logic               out_no_weight
);

  a_reset_empty: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_mean) && $stable(out_first_run))
    else $error("waiting result changed");

  a_empty_seg: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_no_weight |->
      out_mean == 32'sd0 && out_mean_error == 32'hFFFF_FFFF && out_negative_group)
    else $error("empty segment result malformed");

  a_err_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_no_weight |-> out_mean_error != 32'd0)
    else $error("zero error on weighted segment");

endmodule

bind sign_segmented_weighted_mean ssw_checker u_ssw_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_full            (in_full),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_first_run      (out_first_run),
  .out_mean           (out_mean),
  .out_mean_error     (out_mean_error),
  .out_negative_group (out_negative_group),
  .out_no_weight      (out_no_weight)
);
`default_nettype wire

// ===== tb/ssw_mean_checker.sv =====
// Checker for the sign-segmented weighted mean block: predicts every result.
// Depends on ssw_pkg (res_t, segment sign codes); watches all three channels.
`default_nettype none
module ssw_mean_checker import ssw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_invert_negative,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [15:0]        in_run_number,
  input  logic signed [15:0] in_polarization,
  input  logic signed [31:0] in_measurement,
  input  logic [31:0]        in_uncertainty,
  input  logic               in_end_of_data,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic [15:0]        out_first_run,
  input  logic signed [31:0] out_mean,
  input  logic [31:0]        out_mean_error,
  input  logic               out_negative_group,
  input  logic               out_no_weight,
  input  logic               out_last_result,
  output int                 fail_count,
  output int                 results_pending
);

  logic               invert_neg;
  logic [1:0]         seg_sign;
  logic [15:0]        seg_first_run;
  logic [63:0]        weight_sum;
  logic signed [63:0] value_sum;
  logic               any_counted;
  res_t               expected_means[$];

  assign results_pending = expected_means.size();

  function automatic logic [63:0] weight_of(input logic [63:0] d);
    if (d == 64'd1) return '1;
    return ({64{1'b1}} / d) + (((d & (d - 64'd1)) == 64'd0) ? 64'd1 : 64'd0);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, b, x;
    res = 0;
    b = 64'd1 << 62;
    x = v;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // floor(n * 2^32 / d), clipped at 2^32
  function automatic logic [32:0] ratio_q32(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] r, q;
    logic        carry, nb;
    r = 0;
    q = 0;
    for (int i = 0; i < 96; i++) begin
      nb = (i < 64) ? n[63 - i] : 1'b0;
      carry = r[63];
      r = {r[62:0], nb};
      q = q << 1;
      if (carry || r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
      if (q > 64'hFFFF_FFFF) return 33'h1_0000_0000;
    end
    return q[32:0];
  endfunction

  function automatic res_t close_segment(input logic last);
    res_t               r;
    logic               neg_grp, neg;
    logic [63:0]        mag, root;
    logic [32:0]        q;
    logic signed [63:0] m;
    neg_grp = (seg_sign != SEG_POS) || !any_counted;
    r.mean = '0;
    r.mean_error = 32'hFFFF_FFFF;
    if (any_counted && weight_sum != 0) begin
      neg = value_sum < 0;
      mag = neg ? 64'd0 - value_sum : value_sum;
      q = ratio_q32(mag, weight_sum);
      if (neg) m = (q >= 33'h8000_0000) ? -64'sh8000_0000 : -$signed({31'd0, q});
      else     m = (q >= 33'h7FFF_FFFF) ? 64'sh7FFF_FFFF : $signed({31'd0, q});
      if (neg_grp && invert_neg) m = (m == -64'sh8000_0000) ? 64'sh7FFF_FFFF : -m;
      r.mean = m[31:0];
      if (weight_sum != 64'd1) begin
        root = int_sqrt(weight_of(weight_sum));
        r.mean_error = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
      end
    end
    r.first_run = seg_first_run;
    r.negative_group = neg_grp;
    r.no_weight = !any_counted;
    r.last_result = last;
    seg_sign = SEG_NONE;
    weight_sum = 0;
    value_sum = 0;
    any_counted = 1'b0;
    return r;
  endfunction

  // Advance the segment state by one accepted transaction and queue its results.
  task automatic absorb_item();
    logic [1:0]         s;
    logic [63:0]        u2, w, vmag, p;
    logic signed [64:0] total;
    logic signed [63:0] term;
    res_t               got[$];
    s = (in_polarization == 0) ? SEG_ZERO : (in_polarization[15] ? SEG_NEG : SEG_POS);
    if (seg_sign != SEG_NONE && (s != seg_sign || s == SEG_ZERO))
      got = {got, close_segment(1'b0)};
    if (seg_sign == SEG_NONE) begin
      seg_sign = s;
      seg_first_run = in_run_number;
      weight_sum = 0;
      value_sum = 0;
      any_counted = 1'b0;
    end
    if (in_uncertainty != 0) begin
      u2 = {32'd0, in_uncertainty} * {32'd0, in_uncertainty};
      w = weight_of(u2);
      vmag = in_measurement[31] ? 64'h1_0000_0000 - {32'd0, in_measurement}
                                : {32'd0, in_measurement};
      p = vmag * (w >> 32) + ((vmag * (w & 64'hFFFF_FFFF)) >> 32);
      term = in_measurement[31] ? -$signed(p) : $signed(p);
      weight_sum = (weight_sum > ~w) ? '1 : weight_sum + w;
      total = {value_sum[63], value_sum} + {term[63], term};
      if (total > 65'sh0_7FFF_FFFF_FFFF_FFFF)       value_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (total < -65'sh0_8000_0000_0000_0000) value_sum = 64'sh8000_0000_0000_0000;
      else                                          value_sum = total[63:0];
      any_counted = 1'b1;
    end
    if (in_end_of_data || s == SEG_ZERO) got = {got, close_segment(1'b1)};
    else if (got.size() > 0) got[0].last_result = 1'b1;
    foreach (got[i]) expected_means = {expected_means, got[i]};
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("mismatch on %s: got %h, expected %h", field, seen, wanted);
    fail_count++;
  endtask

  task automatic compare_result();
    res_t e;
    if (expected_means.size() == 0) begin
      $display("unexpected result transaction, first_run %h", out_first_run);
      fail_count++;
      return;
    end
    e = expected_means.pop_front();
    if (out_first_run != e.first_run)
      report_mismatch("first_run", 32'(out_first_run), 32'(e.first_run));
    if (out_mean != e.mean) report_mismatch("mean", out_mean, e.mean);
    if (out_mean_error != e.mean_error)
      report_mismatch("mean_error", out_mean_error, e.mean_error);
    if (out_negative_group != e.negative_group)
      report_mismatch("negative_group", 32'(out_negative_group), 32'(e.negative_group));
    if (out_no_weight != e.no_weight)
      report_mismatch("no_weight", 32'(out_no_weight), 32'(e.no_weight));
    if (out_last_result != e.last_result)
      report_mismatch("last_result", 32'(out_last_result), 32'(e.last_result));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count = 0;
      invert_neg = 1'b1;
      seg_sign = SEG_NONE;
      seg_first_run = 0;
      weight_sum = 0;
      value_sum = 0;
      any_counted = 1'b0;
      expected_means.delete();
    end else begin
      if (cfg_we) invert_neg = cfg_invert_negative;
      if (out_pop && !out_empty) compare_result();
      if (in_push && !in_full) absorb_item();
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench top for sign_segmented_weighted_mean: clock, reset, stimulus, verdict.
// Depends on ssw_pkg, the block itself and ssw_mean_checker.
`default_nettype none
module tb import ssw_pkg::*;;

  localparam int IDLE_LIMIT = 20000;   // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES = 400;   // one counted item plus two results, with margin
  localparam int HOLD_CYCLES = 5000;   // long receiver hold-off to fill both queues

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_invert_negative = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [15:0]        in_run_number = '0;
  logic signed [15:0] in_polarization = '0;
  logic signed [31:0] in_measurement = '0;
  logic [31:0]        in_uncertainty = '0;
  logic               in_end_of_data = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [15:0]        out_first_run;
  logic signed [31:0] out_mean;
  logic [31:0]        out_mean_error;
  logic               out_negative_group;
  logic               out_no_weight;
  logic               out_last_result;
  int                 fail_count;
  int                 results_pending;
  int                 burst_left = 0;
  int                 idle_cycles = 0;
  logic               hold_request = 1'b0;
  logic               cur_negative = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sign_segmented_weighted_mean uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_invert_negative(cfg_invert_negative),
    .in_push(in_push), .in_full(in_full), .in_run_number(in_run_number),
    .in_polarization(in_polarization), .in_measurement(in_measurement),
    .in_uncertainty(in_uncertainty), .in_end_of_data(in_end_of_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_first_run(out_first_run),
    .out_mean(out_mean), .out_mean_error(out_mean_error),
    .out_negative_group(out_negative_group), .out_no_weight(out_no_weight),
    .out_last_result(out_last_result)
  );

  ssw_mean_checker mean_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_invert_negative(cfg_invert_negative),
    .in_push(in_push), .in_full(in_full), .in_run_number(in_run_number),
    .in_polarization(in_polarization), .in_measurement(in_measurement),
    .in_uncertainty(in_uncertainty), .in_end_of_data(in_end_of_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_first_run(out_first_run),
    .out_mean(out_mean), .out_mean_error(out_mean_error),
    .out_negative_group(out_negative_group), .out_no_weight(out_no_weight),
    .out_last_result(out_last_result), .fail_count(fail_count),
    .results_pending(results_pending)
  );

  // Watchdog: any transaction on either channel resets the idle count.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: change stall mode every so often, honour one long hold-off on request.
  initial begin : receiver
    int mode;
    int hold_done;
    hold_done = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1;
      end
      if ($urandom_range(0, 150) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: begin
          out_pop <= 1'b1;
        end
        1: begin
          out_pop <= ($urandom_range(0, 3) != 0);
        end
        2: begin
          out_pop <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_pop <= ($urandom_range(0, 1) == 0);
        end
      endcase
    end
  end

  // Offer one transaction; open a random gap first when the current burst runs out.
  task automatic send(input logic [15:0] run, input logic [15:0] pol,
                      input logic [31:0] meas, input logic [31:0] unc, input logic eod);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 30);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    burst_left--;
    in_run_number <= run;
    in_polarization <= pol;
    in_measurement <= meas;
    in_uncertainty <= unc;
    in_end_of_data <= eod;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
  endtask

  // Drop push, let every expected result and any trailing work drain, then write.
  task automatic write_invert(input logic value);
    in_push <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_invert_negative <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly runs of one sign with realistic errors; rare zero polarisation and flips.
  task automatic send_random();
    logic [15:0] pol;
    logic [31:0] meas, unc;
    int          pick;
    if ($urandom_range(0, 99) < 15) cur_negative = !cur_negative;
    pol = cur_negative ? 16'(-$urandom_range(1, 32768)) : 16'($urandom_range(1, 32767));
    if ($urandom_range(0, 99) < 3) pol = 16'd0;
    pick = $urandom_range(0, 9);
    case (pick)
      0: unc = 32'd0;
      1: unc = 32'd1;
      2: unc = $urandom;
      8, 9: unc = $urandom_range(32'h100, 32'hFFFF);
      default: unc = $urandom_range(1, 32'h3_0000);
    endcase
    pick = $urandom_range(0, 19);
    case (pick)
      0: meas = 32'h8000_0000;
      1: meas = 32'h7FFF_FFFF;
      2, 3, 4: meas = $urandom;
      default: meas = 32'($signed($urandom_range(0, 32'h00A0_0000)) - 32'sh0050_0000);
    endcase
    send(16'($urandom), pol, meas, unc, $urandom_range(0, 99) < 4);
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_invert(1'b1);

    // Directed: extremes, sign changes, zero polarisation, empty segments.
    send(16'h0000, 16'h0001, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send(16'hFFFF, 16'h7FFF, 32'h7FFF_FFFF, 32'd1, 1'b0);
    send(16'h1234, 16'h8000, 32'h8000_0000, 32'd1, 1'b1);      // sign change and end
    send(16'h0042, 16'h8000, 32'h8000_0000, 32'd1, 1'b1);      // negated minimum
    send(16'h0043, 16'h0000, 32'h0002_0000, 32'h0000_8000, 1'b0); // zero polarisation
    send(16'h0044, 16'h0100, 32'h0003_0000, 32'd0, 1'b0);      // skipped item
    send(16'h0045, 16'h0000, 32'h0000_0000, 32'd0, 1'b0);      // closes empty segment
    send(16'h0046, 16'hFF00, 32'hFFFF_0000, 32'd0, 1'b1);      // empty negative segment
    send(16'h0047, 16'h0080, 32'h0005_0000, 32'hFFFF_FFFF, 1'b0);
    send(16'h0048, 16'h0080, 32'hFFFB_0000, 32'h0000_0001, 1'b0);
    send(16'h0049, 16'hFFFF, 32'h0000_0001, 32'h0002_0000, 1'b0);
    send(16'h004A, 16'h0001, 32'h0100_0000, 32'h0001_0000, 1'b0);
    send(16'h004B, 16'hFFFF, 32'hAAAA_5555, 32'h5555_AAAA, 1'b0);
    send(16'h004C, 16'hFFFF, 32'h5555_AAAA, 32'hAAAA_5555, 1'b1);
    send(16'h004D, 16'h0000, 32'h7FFF_FFFF, 32'd1, 1'b1);      // zero polarisation at end
    send(16'h004E, 16'h4000, 32'h0000_0000, 32'h0000_0001, 1'b1);

    write_invert(1'b0);
    repeat (275) send_random();
    send(16'($urandom), 16'h0001, 32'h0001_0000, 32'h0001_0000, 1'b1);

    write_invert(1'b1);
    hold_request <= 1'b1;
    repeat (275) send_random();
    send(16'($urandom), 16'hFFFF, 32'h0001_0000, 32'h0001_0000, 1'b1);

    in_push <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
